FILE: design/gmfc_pkg.sv
// ---------------------------------------------------------------------------
// gmfc_pkg
// Shared constants, codes, types and small tables of the grid mask face
// culler: field widths, request and face codes, corner and shade tables.
// ---------------------------------------------------------------------------
package gmfc_pkg;

	localparam int MAP_SIDE    = 256;
	localparam int CELL_SIZE   = 12;
	localparam int SLAB_HEIGHT = 4;

	localparam int MASK_DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int MASK_AW    = $clog2(MASK_DEPTH);
	localparam int IDX_W      = $clog2(MAP_SIDE);
	localparam int SIZEQ_W    = IDX_W + 1;

	localparam int REQ_W     = 2;
	localparam int ADDR_W    = 16;
	localparam int ALPHA_W   = 8;
	localparam int COL_W     = 22;
	localparam int SCROLL_W  = 31;
	localparam int LOOK_W    = SCROLL_W + 1;
	localparam int MOD_CNT_W = $clog2(LOOK_W + 1);
	localparam int POS_W     = 25;
	localparam int POSY_W    = 3;
	localparam int FACE_W    = 3;
	localparam int SHADE_W   = 9;
	localparam int VIDX_W    = 16;
	localparam int SIZE_W    = 9;
	localparam int CFG_IDX_W = 1;
	localparam int NUM_FACES = 6;
	localparam int NUM_READS = 5;
	localparam int RD_CNT_W  = $clog2(NUM_READS + 1);

	localparam logic [ALPHA_W-1:0] ALPHA_LIMIT = 8'h7F;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_BUILD = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

	// face codes
	localparam logic [FACE_W-1:0] FACE_UP    = 3'd0;
	localparam logic [FACE_W-1:0] FACE_DOWN  = 3'd1;
	localparam logic [FACE_W-1:0] FACE_LEFT  = 3'd2;
	localparam logic [FACE_W-1:0] FACE_RIGHT = 3'd3;
	localparam logic [FACE_W-1:0] FACE_BACK  = 3'd4;
	localparam logic [FACE_W-1:0] FACE_FRONT = 3'd5;

	// mask read order of a build
	localparam logic [RD_CNT_W-1:0] RD_CENTER = 3'd0;
	localparam logic [RD_CNT_W-1:0] RD_LEFT   = 3'd1;
	localparam logic [RD_CNT_W-1:0] RD_RIGHT  = 3'd2;
	localparam logic [RD_CNT_W-1:0] RD_BACK   = 3'd3;
	localparam logic [RD_CNT_W-1:0] RD_FRONT  = 3'd4;
	localparam logic [RD_CNT_W-1:0] RD_DONE   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_COL,
		ST_MOD_ROW,
		ST_NBR,
		ST_READ,
		ST_DECIDE
	} gmfc_state_t;

	typedef struct packed {
		logic                        start;
		logic                        clear_count;
		logic [NUM_FACES-1:0]        faces;
		logic signed [COL_W-1:0]     col;
		logic signed [COL_W-1:0]     row;
	} gmfc_emit_cmd_t;

	// register value 0 acts as 1, anything above the side acts as the side
	function automatic logic [SIZEQ_W-1:0] gmfc_eff_size(input logic [SIZE_W-1:0] r);
		logic [SIZEQ_W-1:0] s;
		if (r == '0) begin
			s = SIZEQ_W'(1);
		end else if (32'(r) > MAP_SIDE) begin
			s = SIZEQ_W'(MAP_SIDE);
		end else begin
			s = SIZEQ_W'(r);
		end
		return s;
	endfunction

	// corner code: bit0 +x, bit1 top, bit2 +z
	function automatic logic [2:0] gmfc_corner(input logic [FACE_W-1:0] f,
			input logic [1:0] v);
		logic [11:0] row;
		case (f)
			FACE_UP:    row = {3'd7, 3'd3, 3'd6, 3'd2};
			FACE_DOWN:  row = {3'd5, 3'd4, 3'd1, 3'd0};
			FACE_LEFT:  row = {3'd6, 3'd2, 3'd4, 3'd0};
			FACE_RIGHT: row = {3'd7, 3'd5, 3'd3, 3'd1};
			FACE_BACK:  row = {3'd3, 3'd1, 3'd2, 3'd0};
			FACE_FRONT: row = {3'd7, 3'd6, 3'd5, 3'd4};
			default:    row = '0;
		endcase
		return row[v*3 +: 3];
	endfunction

	function automatic logic [SHADE_W-1:0] gmfc_face_shade(input logic [FACE_W-1:0] f);
		logic [SHADE_W-1:0] s;
		case (f)
			FACE_UP:    s = 9'd256;
			FACE_DOWN:  s = 9'd179;
			FACE_LEFT:  s = 9'd205;
			FACE_RIGHT: s = 9'd205;
			FACE_BACK:  s = 9'd230;
			FACE_FRONT: s = 9'd230;
			default:    s = '0;
		endcase
		return s;
	endfunction

endpackage

FILE: design/gmfc_if.sv
// ---------------------------------------------------------------------------
// gmfc_if
// Valid/ready channels of the face culler: request words, vertex words and
// configuration writes.
// ---------------------------------------------------------------------------
interface gmfc_req_if;
	import gmfc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [REQ_W-1:0]           req_type;
	logic [ADDR_W-1:0]          texel_addr;
	logic [ALPHA_W-1:0]         texel_alpha;
	logic signed [COL_W-1:0]    cell_col;
	logic signed [COL_W-1:0]    cell_row;
	logic signed [SCROLL_W-1:0] scroll;

	modport source (output valid, req_type, texel_addr, texel_alpha, cell_col, cell_row,
		scroll, input ready);
	modport sink (input valid, req_type, texel_addr, texel_alpha, cell_col, cell_row,
		scroll, output ready);
endinterface

interface gmfc_vtx_if;
	import gmfc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic [POSY_W-1:0]       pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [FACE_W-1:0]       face_kind;
	logic [SHADE_W-1:0]      shade;
	logic [VIDX_W-1:0]       vertex_index;
	logic                    last_vertex;

	modport source (output valid, pos_x, pos_y, pos_z, face_kind, shade, vertex_index,
		last_vertex, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, face_kind, shade, vertex_index,
		last_vertex, output ready);
endinterface

interface gmfc_cfg_if;
	import gmfc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/gmfc_mod_unit.sv
// ---------------------------------------------------------------------------
// gmfc_mod_unit
// Bit-serial true modulo of a signed value by a map size: one quotient bit
// per cycle on the magnitude, then a sign fix-up step.
// ---------------------------------------------------------------------------
module gmfc_mod_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [gmfc_pkg::LOOK_W-1:0]  value,
	input  logic [gmfc_pkg::SIZEQ_W-1:0]        modulus,
	output logic                                done,
	output logic [gmfc_pkg::IDX_W-1:0]          result
);
	import gmfc_pkg::*;

	logic [LOOK_W-1:0]    mag_q;
	logic [SIZEQ_W-1:0]   rem_q;
	logic [SIZEQ_W-1:0]   mod_q;
	logic                 neg_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 fix_q;
	logic [SIZEQ_W:0]     trial;
	logic [SIZEQ_W:0]     diff;

	assign trial = {rem_q, mag_q[LOOK_W-1]};
	assign diff  = trial - {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MOD_CNT_W'(LOOK_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MOD_CNT_W'(1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= value[LOOK_W-1];
			mag_q <= value[LOOK_W-1] ? LOOK_W'(-value) : LOOK_W'(value);
			rem_q <= '0;
			mod_q <= modulus;
		end else if (busy_q) begin
			mag_q <= mag_q << 1;
			rem_q <= (trial >= {1'b0, mod_q}) ? diff[SIZEQ_W-1:0] : trial[SIZEQ_W-1:0];
		end else if (fix_q) begin
			// negative operand with a remainder folds back into range
			if (neg_q && rem_q != '0) begin
				rem_q <= mod_q - rem_q;
			end
		end
	end

	assign result = rem_q[IDX_W-1:0];

endmodule

FILE: design/gmfc_mask_ram.sv
// ---------------------------------------------------------------------------
// gmfc_mask_ram
// One-bit fill mask, one write port and one registered read port.
// ---------------------------------------------------------------------------
module gmfc_mask_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [gmfc_pkg::MASK_AW-1:0] waddr,
	input  logic                         wdata,
	input  logic [gmfc_pkg::MASK_AW-1:0] raddr,
	output logic                         rdata
);
	import gmfc_pkg::*;

	logic mem_q [MASK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/gmfc_vtx_gen.sv
// ---------------------------------------------------------------------------
// gmfc_vtx_gen
// Walks the visible faces of a cell, four corners each; one vertex word per
// cycle while vtx is ready, via an output register; owns the vertex counter.
// ---------------------------------------------------------------------------
module gmfc_vtx_gen (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gmfc_pkg::gmfc_emit_cmd_t cmd,
	output logic                     active,
	gmfc_vtx_if.source               vtx
);
	import gmfc_pkg::*;

	logic                    active_q;
	logic [NUM_FACES-1:0]    faces_q;
	logic [FACE_W-1:0]       face_q;
	logic [1:0]              vert_q;
	logic [VIDX_W-1:0]       vcount_q;
	logic signed [POS_W-1:0] x0_q;
	logic signed [POS_W-1:0] z0_q;
	logic                    out_valid_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic [POSY_W-1:0]       pos_y_q;
	logic signed [POS_W-1:0] pos_z_q;
	logic [FACE_W-1:0]       face_kind_q;
	logic [VIDX_W-1:0]       vidx_q;
	logic                    last_q;

	logic                 advance;
	logic [NUM_FACES-1:0] faces_left;
	logic [FACE_W-1:0]    next_face;
	logic                 face_end;
	logic                 last;
	logic [2:0]           corner;

	assign advance    = active_q && (!out_valid_q || vtx.ready);
	assign faces_left = faces_q & ~(NUM_FACES'(1) << face_q);
	assign face_end   = (vert_q == 2'd3);
	assign last       = face_end && (faces_left == '0);
	assign corner     = gmfc_corner(face_q, vert_q);

	// lowest face still to go
	always_comb begin
		next_face = face_q;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (faces_left[i]) begin
				next_face = FACE_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			faces_q     <= '0;
			face_q      <= FACE_UP;
			vert_q      <= '0;
			vcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_count) begin
				vcount_q <= '0;
			end
			if (cmd.start) begin
				active_q <= 1'b1;
				faces_q  <= cmd.faces;
				face_q   <= FACE_UP;
				vert_q   <= '0;
			end else if (advance) begin
				vcount_q <= vcount_q + 1'b1;
				vert_q   <= vert_q + 1'b1;
				if (face_end) begin
					faces_q <= faces_left;
					face_q  <= next_face;
					if (last) begin
						active_q <= 1'b0;
					end
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (vtx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x0_q <= POS_W'(cmd.col) * POS_W'(CELL_SIZE);
			z0_q <= POS_W'(cmd.row) * POS_W'(CELL_SIZE);
		end
		if (advance) begin
			pos_x_q     <= x0_q + (corner[0] ? POS_W'(CELL_SIZE) : POS_W'(0));
			pos_y_q     <= corner[1] ? POSY_W'(SLAB_HEIGHT) : POSY_W'(0);
			pos_z_q     <= z0_q + (corner[2] ? POS_W'(CELL_SIZE) : POS_W'(0));
			face_kind_q <= face_q;
			vidx_q      <= vcount_q;
			last_q      <= last;
		end
	end

	assign active           = active_q;
	assign vtx.valid        = out_valid_q;
	assign vtx.pos_x        = pos_x_q;
	assign vtx.pos_y        = pos_y_q;
	assign vtx.pos_z        = pos_z_q;
	assign vtx.face_kind    = face_kind_q;
	assign vtx.shade        = gmfc_face_shade(face_kind_q);
	assign vtx.vertex_index = vidx_q;
	assign vtx.last_vertex  = last_q;

endmodule

FILE: design/grid_mask_face_culler.sv
// ---------------------------------------------------------------------------
// grid_mask_face_culler
// Fill-mask slab mesher: load, start and build request words in, one vertex
// word out per visible corner.
//
// Channels: req takes load (one mask bit), start (clears the vertex counter)
// and build (one cell) words; vtx gives vertex words; cfg writes map_width
// and map_height. An item is taken when valid and ready are both high.
// Load and start keep req.ready high. A build gives its first vertex word
// after the lookups and mask reads, then one vertex word per cycle while
// vtx is ready (8 to 24 for a filled cell): the column and the row lookup
// each pass through the shared bit-serial modulo unit, 32 steps plus a
// fix-up step, and the five mask reads share one read port. An empty cell
// gives no vertex word and frees the request side once back in idle.
// req.ready stays low until the last vertex of a cell sits in the output
// register. A stalled vtx receiver holds that register and the vertex
// walk; the next request word is taken once the walk is done.
// Reset sets both map sizes to 256 and the vertex counter to zero; the mask
// has no clearing pass and holds no defined data until it is loaded.
// ---------------------------------------------------------------------------
module grid_mask_face_culler (
	input  logic       clk,
	input  logic       arst_n,
	gmfc_req_if.sink   req,
	gmfc_vtx_if.source vtx,
	gmfc_cfg_if.sink   cfg
);
	import gmfc_pkg::*;

	gmfc_state_t state_q, state_d;

	logic [SIZE_W-1:0]       width_q;
	logic [SIZE_W-1:0]       height_q;
	logic [SIZEQ_W-1:0]      w_eff;
	logic [SIZEQ_W-1:0]      h_eff;
	logic signed [COL_W-1:0] col_q;
	logic signed [COL_W-1:0] row_q;
	logic [IDX_W-1:0]        c_q, cl_q, cr_q;
	logic [IDX_W-1:0]        r_q, rb_q, rf_q;
	logic [RD_CNT_W-1:0]     rd_idx_q;
	logic [NUM_READS-1:0]    hit_q;

	logic                    accept;
	logic                    emit_active;
	logic                    mod_start;
	logic signed [LOOK_W-1:0] mod_value;
	logic [SIZEQ_W-1:0]      mod_modulus;
	logic                    mod_done;
	logic [IDX_W-1:0]        mod_result;
	gmfc_emit_cmd_t          emit_cmd;

	logic                    mask_we;
	logic                    mask_rdata;
	logic [IDX_W-1:0]        rsel, csel;
	logic [IDX_W+SIZEQ_W-1:0] prod;
	logic [MASK_AW-1:0]      rd_addr;

	assign w_eff     = gmfc_eff_size(width_q);
	assign h_eff     = gmfc_eff_size(height_q);
	assign req.ready = (state_q == ST_IDLE) && !emit_active;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(MAP_SIDE);
			height_q <= SIZE_W'(MAP_SIDE);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAP_WIDTH:  width_q  <= cfg.data;
				REG_MAP_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.req_type == REQ_BUILD) begin
					state_d = ST_MOD_COL;
				end
			end
			ST_MOD_COL: begin
				if (mod_done) begin
					state_d = ST_MOD_ROW;
				end
			end
			ST_MOD_ROW: begin
				if (mod_done) begin
					state_d = ST_NBR;
				end
			end
			ST_NBR:   state_d = ST_READ;
			ST_READ: begin
				if (rd_idx_q == RD_DONE) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mod_start            = 1'b0;
		mod_value            = LOOK_W'(req.cell_col) + LOOK_W'(req.scroll);
		mod_modulus          = w_eff;
		mask_we              = 1'b0;
		emit_cmd.start       = 1'b0;
		emit_cmd.clear_count = 1'b0;
		emit_cmd.faces       = {~hit_q[RD_FRONT], ~hit_q[RD_BACK], ~hit_q[RD_RIGHT],
			~hit_q[RD_LEFT], 1'b1, 1'b1};
		emit_cmd.col         = col_q;
		emit_cmd.row         = row_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mod_start            = (req.req_type == REQ_BUILD);
					mask_we              = (req.req_type == REQ_LOAD) &&
						(32'(req.texel_addr) < MASK_DEPTH);
					emit_cmd.clear_count = (req.req_type == REQ_START);
				end
			end
			ST_MOD_COL: begin
				mod_start   = mod_done;
				mod_value   = LOOK_W'(row_q);
				mod_modulus = h_eff;
			end
			ST_DECIDE: emit_cmd.start = hit_q[RD_CENTER];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end else begin
				rd_idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= req.cell_col;
			row_q <= req.cell_row;
		end
		if (state_q == ST_MOD_COL && mod_done) begin
			c_q <= mod_result;
		end
		if (state_q == ST_MOD_ROW && mod_done) begin
			r_q <= mod_result;
		end
		if (state_q == ST_NBR) begin
			// neighbors wrap around the map edges
			cl_q <= (c_q == '0) ? IDX_W'(w_eff - 1'b1) : c_q - 1'b1;
			cr_q <= (SIZEQ_W'(c_q) + 1'b1 == w_eff) ? '0 : c_q + 1'b1;
			rb_q <= (r_q == '0) ? IDX_W'(h_eff - 1'b1) : r_q - 1'b1;
			rf_q <= (SIZEQ_W'(r_q) + 1'b1 == h_eff) ? '0 : r_q + 1'b1;
		end
		// read data arrives in the cycle after its address
		if (state_q == ST_READ && rd_idx_q != RD_CENTER) begin
			hit_q[rd_idx_q - 1'b1] <= mask_rdata;
		end
	end

	always_comb begin
		rsel = r_q;
		csel = c_q;
		case (rd_idx_q)
			RD_LEFT:  csel = cl_q;
			RD_RIGHT: csel = cr_q;
			RD_BACK:  rsel = rb_q;
			RD_FRONT: rsel = rf_q;
			default: ;
		endcase
	end

	assign prod    = rsel * w_eff;
	assign rd_addr = MASK_AW'(prod + (IDX_W + SIZEQ_W)'(csel));

	gmfc_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.value   (mod_value),
		.modulus (mod_modulus),
		.done    (mod_done),
		.result  (mod_result)
	);

	gmfc_mask_ram u_mask (
		.clk   (clk),
		.we    (mask_we),
		.waddr (MASK_AW'(req.texel_addr)),
		.wdata (req.texel_alpha > ALPHA_LIMIT),
		.raddr (rd_addr),
		.rdata (mask_rdata)
	);

	gmfc_vtx_gen u_vtx (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (emit_cmd),
		.active (emit_active),
		.vtx    (vtx)
	);

endmodule

FILE: design/gmfc_checker.sv
// ---------------------------------------------------------------------------
// gmfc_checker
// Port-level checks of the face culler, bound to the top level.
// ---------------------------------------------------------------------------
module gmfc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic [gmfc_pkg::REQ_W-1:0]          req_type,
	input logic                                vtx_valid,
	input logic                                vtx_ready,
	input logic signed [gmfc_pkg::POS_W-1:0]   pos_x,
	input logic [gmfc_pkg::POSY_W-1:0]         pos_y,
	input logic signed [gmfc_pkg::POS_W-1:0]   pos_z,
	input logic [gmfc_pkg::FACE_W-1:0]         face_kind,
	input logic [gmfc_pkg::SHADE_W-1:0]        shade,
	input logic [gmfc_pkg::VIDX_W-1:0]         vertex_index,
	input logic                                last_vertex
);
	import gmfc_pkg::*;

	// a stalled vertex word holds
	a_vtx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_ready |=> vtx_valid &&
		$stable({pos_x, pos_y, pos_z, face_kind, shade, vertex_index, last_vertex}))
		else $error("vertex word changed under stall");

	a_shade: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> shade == gmfc_face_shade(face_kind))
		else $error("shade does not match face");

	// a build keeps the request side closed in the cycle after its acceptance
	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_BUILD |=> !req_ready)
		else $error("request taken right after a build");

	// more vertices of the cell still to come
	a_mid_cell: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !last_vertex |-> !req_ready)
		else $error("request side open in the middle of a cell");

endmodule

bind grid_mask_face_culler gmfc_checker u_gmfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_type     (req.req_type),
	.vtx_valid    (vtx.valid),
	.vtx_ready    (vtx.ready),
	.pos_x        (vtx.pos_x),
	.pos_y        (vtx.pos_y),
	.pos_z        (vtx.pos_z),
	.face_kind    (vtx.face_kind),
	.shade        (vtx.shade),
	.vertex_index (vtx.vertex_index),
	.last_vertex  (vtx.last_vertex)
);
